// File: sv/rhni_pkg.sv
// Package for region_hit_and_nearest_icon: sizes, codes and sequencer states.
// No dependencies.
package rhni_pkg;

   localparam int MaxPoints = 64;
   localparam int MaxRects  = 64;
   localparam int CoordBits = 12;
   localparam int PtIdxBits = $clog2(MaxPoints);
   localparam int RcIdxBits = $clog2(MaxRects);
   localparam int DistBits  = 2 * CoordBits + 1;

   typedef logic [CoordBits-1:0] coord_type;
   typedef logic [DistBits-1:0]  dist_type;

   localparam logic [1:0] MODE_ICON  = 2'd0;
   localparam logic [1:0] MODE_RECT  = 2'd1;
   localparam logic [1:0] MODE_CLICK = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [1:0] KIND_RECT = 2'd0;
   localparam logic [1:0] KIND_ICON = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ICON_SCAN,
      ST_RECT_SCAN,
      ST_CLICK_RECT,
      ST_MIN_SCAN,
      ST_TIE_SCAN,
      ST_TIE_WAIT,
      ST_OUT
   } state_type;

endpackage

// File: sv/rhni_geom.sv
// Shared geometry unit: inclusive rectangle containment and squared distance.
// Depends on rhni_pkg.
module rhni_geom (
   input  rhni_pkg::coord_type px,
   input  rhni_pkg::coord_type py,
   input  rhni_pkg::coord_type qx,
   input  rhni_pkg::coord_type qy,
   input  rhni_pkg::coord_type rl,
   input  rhni_pkg::coord_type rt,
   input  rhni_pkg::coord_type rr,
   input  rhni_pkg::coord_type rb,
   output logic                inside_rect,
   output rhni_pkg::dist_type  dist_sq
);
   rhni_pkg::coord_type dx, dy;
   logic [2*rhni_pkg::CoordBits-1:0] sx, sy;

   assign inside_rect = (px >= rl) && (py >= rt) && (px <= rr) && (py <= rb);
   assign dx = (px > qx) ? px - qx : qx - px;
   assign dy = (py > qy) ? py - qy : qy - py;
   assign sx = dx * dx;
   assign sy = dy * dy;
   assign dist_sq = {1'b0, sx} + {1'b0, sy};
endmodule

// File: sv/region_hit_and_nearest_icon.sv
// Top level: icon/rectangle tables, sequencer, and result register.
// Depends on rhni_pkg and rhni_geom.
//
//  channel | dir | fields (tdata low bit up)               | tuser
//  req_    | in  | x[11:0] y[23:12] x_far[35:24] y_far[47:36] | mode[1:0]
//  rsp_    | out | index[5:0] (byte padded)                 | kind[1:0], tlast=last
//
// Steps after acceptance. Add icon: the stored rectangles are scanned for cover;
// add rectangle: the stored icons are scanned for cover. Click: the rectangles are
// scanned newest first (ends early on a hit), then the icons in a min scan and a
// tie scan; each tied result but the last waits in ST_TIE_WAIT until taken, and
// ST_OUT emits the last. Stalls on rsp_tready hold the tie scan and ST_OUT.
// req_tready is high only when idle with no result waiting. Reset clears counts and flags.
module region_hit_and_nearest_icon (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // x, y, x_far, y_far
   input  logic [1:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // index, zero pad
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast
);
   localparam int CB = rhni_pkg::CoordBits;
   localparam int PB = rhni_pkg::PtIdxBits;
   localparam int RB = rhni_pkg::RcIdxBits;

   rhni_pkg::state_type state_ff, state_in;

   logic [4*CB-1:0] rect_mem [rhni_pkg::MaxRects];
   logic [2*CB-1:0] pt_mem   [rhni_pkg::MaxPoints];
   logic [rhni_pkg::MaxPoints-1:0] cov_ff, cov_in;
   logic [RB:0] rcnt_ff, rcnt_in;
   logic [PB:0] pcnt_ff, pcnt_in;

   rhni_pkg::coord_type ax_ff, ay_ff, bx_ff, by_ff, ax_in, ay_in, bx_in, by_in;
   logic [RB:0] j_ff, j_in;       // shared scan counter
   logic [4*CB-1:0] rrd_ff;
   logic [2*CB-1:0] prd_ff;
   rhni_pkg::dist_type best_ff, best_in;
   logic any_ff, any_in, cov_hit_ff, cov_hit_in;
   logic [PB-1:0] pend_ff, pend_in;
   logic pend_v_ff, pend_v_in;

   logic       o_valid_ff, o_valid_in, o_last_ff, o_last_in;
   logic [1:0] o_kind_ff, o_kind_in;
   logic [5:0] o_idx_ff, o_idx_in;

   logic rd_en;
   logic [RB-1:0] r_addr;
   logic [PB-1:0] p_addr;
   logic we_r, we_p;

   rhni_pkg::coord_type gpx, gpy, gqx, gqy;
   logic in_rect;
   rhni_pkg::dist_type dist_sq;

   // reads are registered: j_ff (j_ff-1 in click scan) addresses, data arrive next cycle
   logic rv_ff;
   logic [RB:0] jd_ff;

   rhni_geom u_geom (
      .px(gpx), .py(gpy), .qx(gqx), .qy(gqy),
      .rl(rrd_ff[CB-1:0]), .rt(rrd_ff[2*CB-1:CB]),
      .rr(rrd_ff[3*CB-1:2*CB]), .rb(rrd_ff[4*CB-1:3*CB]),
      .inside_rect(in_rect), .dist_sq(dist_sq)
   );

   always_comb begin
      // icon scan tests the new icon; rect scan tests stored icons vs new rect
      gpx = ax_ff; gpy = ay_ff; gqx = prd_ff[CB-1:0]; gqy = prd_ff[2*CB-1:CB];
      if (state_ff == rhni_pkg::ST_RECT_SCAN) begin
         gpx = prd_ff[CB-1:0]; gpy = prd_ff[2*CB-1:CB];
      end
   end

   always_ff @(posedge clock) begin
      if (we_r) rect_mem[rcnt_ff[RB-1:0]] <= {by_ff, bx_ff, ay_ff, ax_ff};
      if (we_p) pt_mem[pcnt_ff[PB-1:0]]   <= {ay_ff, ax_ff};
      if (rd_en) prd_ff <= pt_mem[p_addr];
      // in rect scan the rectangle under test is the new one held in registers
      if (state_ff == rhni_pkg::ST_RECT_SCAN)
         rrd_ff <= {by_ff, bx_ff, ay_ff, ax_ff};
      else if (rd_en)
         rrd_ff <= rect_mem[r_addr];
   end

   always_comb begin
      state_in = state_ff; cov_in = cov_ff; rcnt_in = rcnt_ff; pcnt_in = pcnt_ff;
      ax_in = ax_ff; ay_in = ay_ff; bx_in = bx_ff; by_in = by_ff;
      j_in = j_ff; best_in = best_ff; any_in = any_ff; cov_hit_in = cov_hit_ff;
      pend_in = pend_ff; pend_v_in = pend_v_ff;
      o_valid_in = o_valid_ff; o_last_in = o_last_ff;
      o_kind_in = o_kind_ff; o_idx_in = o_idx_ff;
      rd_en = 1'b0; r_addr = j_ff[RB-1:0]; p_addr = j_ff[PB-1:0];
      we_r = 1'b0; we_p = 1'b0;
      req_tready = 1'b0;
      if (o_valid_ff && rsp_tready) o_valid_in = 1'b0;

      case (state_ff)
         rhni_pkg::ST_IDLE: begin
            req_tready = !o_valid_ff;
            if (req_tvalid && !o_valid_ff) begin
               ax_in = req_tdata[CB-1:0];      ay_in = req_tdata[2*CB-1:CB];
               bx_in = req_tdata[3*CB-1:2*CB]; by_in = req_tdata[4*CB-1:3*CB];
               j_in = '0; cov_hit_in = 1'b0; any_in = 1'b0;
               case (req_tuser)
                  rhni_pkg::MODE_ICON:
                     if (pcnt_ff < (PB+1)'(rhni_pkg::MaxPoints))
                        state_in = rhni_pkg::ST_ICON_SCAN;
                  rhni_pkg::MODE_RECT:
                     if (rcnt_ff < (RB+1)'(rhni_pkg::MaxRects))
                        state_in = rhni_pkg::ST_RECT_SCAN;
                  rhni_pkg::MODE_CLICK: begin
                     j_in = rcnt_ff;  // scan newest first
                     state_in = rhni_pkg::ST_CLICK_RECT;
                  end
                  default: ;
               endcase
            end
         end
         rhni_pkg::ST_ICON_SCAN: begin
            if (rv_ff && in_rect) cov_hit_in = 1'b1;
            if (j_ff < rcnt_ff) begin
               rd_en = 1'b1; j_in = j_ff + 1'b1;
            end else if (!rv_ff) begin
               we_p = 1'b1;
               cov_in[pcnt_ff[PB-1:0]] = cov_hit_ff;
               pcnt_in = pcnt_ff + 1'b1;
               state_in = rhni_pkg::ST_IDLE;
            end
         end
         rhni_pkg::ST_RECT_SCAN: begin
            if (rv_ff && in_rect) cov_in[jd_ff[PB-1:0]] = 1'b1;
            if ((PB+1)'(j_ff) < pcnt_ff) begin
               rd_en = 1'b1; j_in = j_ff + 1'b1;
            end else if (!rv_ff) begin
               we_r = 1'b1; rcnt_in = rcnt_ff + 1'b1;
               state_in = rhni_pkg::ST_IDLE;
            end
         end
         rhni_pkg::ST_CLICK_RECT: begin
            r_addr = RB'(j_ff - 1'b1);
            if (rv_ff && in_rect) begin
               o_valid_in = 1'b1; o_kind_in = rhni_pkg::KIND_RECT;
               o_idx_in = 6'(jd_ff); o_last_in = 1'b1;
               state_in = rhni_pkg::ST_IDLE;
            end else if (j_ff != '0) begin
               rd_en = 1'b1; j_in = j_ff - 1'b1;
            end else if (!rv_ff) begin
               state_in = rhni_pkg::ST_MIN_SCAN;
            end
         end
         rhni_pkg::ST_MIN_SCAN: begin
            if (rv_ff && !cov_ff[jd_ff[PB-1:0]] && (!any_ff || dist_sq < best_ff)) begin
               best_in = dist_sq; any_in = 1'b1;
            end
            if ((PB+1)'(j_ff) < pcnt_ff) begin
               rd_en = 1'b1; j_in = j_ff + 1'b1;
            end else if (!rv_ff) begin
               j_in = '0; pend_v_in = 1'b0;
               if (!any_in) begin
                  o_valid_in = 1'b1; o_kind_in = rhni_pkg::KIND_NONE;
                  o_idx_in = '0; o_last_in = 1'b1;
                  state_in = rhni_pkg::ST_IDLE;
               end else state_in = rhni_pkg::ST_TIE_SCAN;
            end
         end
         rhni_pkg::ST_TIE_SCAN: begin
            // a match is held back until the next match so the final one can carry last
            if (rv_ff && !cov_ff[jd_ff[PB-1:0]] && dist_sq == best_ff) begin
               if (pend_v_ff) begin
                  o_valid_in = 1'b1; o_kind_in = rhni_pkg::KIND_ICON;
                  o_idx_in = 6'(pend_ff);
                  o_last_in = 1'b0;
               end
               pend_in = jd_ff[PB-1:0]; pend_v_in = 1'b1;
            end
            if ((PB+1)'(j_ff) < pcnt_ff) begin
               rd_en = 1'b1; j_in = j_ff + 1'b1;
               if (rv_ff && !cov_ff[jd_ff[PB-1:0]] && dist_sq == best_ff && pend_v_ff)
                  state_in = rhni_pkg::ST_TIE_WAIT;
            end else if (!rv_ff) begin
               state_in = rhni_pkg::ST_OUT;
            end else if (rv_ff && !cov_ff[jd_ff[PB-1:0]] && dist_sq == best_ff && pend_v_ff)
               state_in = rhni_pkg::ST_TIE_WAIT;
         end
         rhni_pkg::ST_TIE_WAIT: begin
            // hold until the emitted item leaves; the in-flight read is kept
            if (!o_valid_ff || rsp_tready) state_in = rhni_pkg::ST_TIE_SCAN;
         end
         rhni_pkg::ST_OUT: begin
            if (!o_valid_ff || rsp_tready) begin
               o_valid_in = 1'b1; o_kind_in = rhni_pkg::KIND_ICON;
               o_idx_in = 6'(pend_ff); o_last_in = 1'b1;
               state_in = rhni_pkg::ST_IDLE;
            end
         end
         default: state_in = rhni_pkg::ST_IDLE;
      endcase
   end

   // read pipeline stalls with the sequencer in ST_TIE_WAIT
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhni_pkg::ST_IDLE;
         cov_ff <= '0; rcnt_ff <= '0; pcnt_ff <= '0;
         o_valid_ff <= 1'b0; rv_ff <= 1'b0; pend_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cov_ff <= cov_in; rcnt_ff <= rcnt_in; pcnt_ff <= pcnt_in;
         o_valid_ff <= o_valid_in; pend_v_ff <= pend_v_in;
         if (state_ff != rhni_pkg::ST_TIE_WAIT) rv_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in; ay_ff <= ay_in; bx_ff <= bx_in; by_ff <= by_in;
      j_ff <= j_in; best_ff <= best_in; any_ff <= any_in; cov_hit_ff <= cov_hit_in;
      pend_ff <= pend_in;
      o_last_ff <= o_last_in; o_kind_ff <= o_kind_in; o_idx_ff <= o_idx_in;
      if (state_ff != rhni_pkg::ST_TIE_WAIT && rd_en)
         jd_ff <= (state_ff == rhni_pkg::ST_CLICK_RECT) ? j_ff - 1'b1 : j_ff;
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {2'b00, o_idx_ff};
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;
endmodule
